[rtl/core/rar_pkg.sv]
// shared types, constants and helpers for the rational arithmetic reduction core
`default_nettype none

package rar_pkg;

  // datapath and field widths
  localparam int DataW          = 32;
  localparam int OperandW       = 16;
  localparam int OpW            = 2;
  localparam int OperandBitsDef = 16;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } rar_op_e;

  // request into the shared divider
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } rar_div_req_t;

  // response from the shared divider
  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quot;
    logic [DataW-1:0] rem;
  } rar_div_rsp_t;

  // take the low bits operand bits of a field and extend their sign to the datapath
  function automatic logic [DataW-1:0] sext_operand(logic [OperandW-1:0] v, int bits);
    logic [DataW-1:0] v_ext;
    logic [DataW-1:0] r;
    v_ext = {{(DataW-OperandW){1'b0}}, v};
    for (int i = 0; i < DataW; i++) begin
      r[i] = (i < bits) ? v_ext[i] : v_ext[bits-1];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/rational_arith_reduce_core.sv]
// sequence: products from the shared multiplier, then euclid remainder steps on the
// shared divider until the remainder is zero, then the divisions of numerator and
// denominator by the resulting divisor
// throughput: one transaction at a time; in_stall_o stays high from accept until the
// result is taken, the shared divider sets the pace
// reset: rst_ni asynchronous active low, returns the sequencer to idle with no result held
`default_nettype none

module rational_arith_reduce_core
  import rar_pkg::*;
#(
  parameter int OPERAND_BITS = OperandBitsDef
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // input channel
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire  [OpW-1:0]       req_type_i,
  input  wire  [OperandW-1:0]  a_num_i,
  input  wire  [OperandW-1:0]  a_den_i,
  input  wire  [OperandW-1:0]  b_num_i,
  input  wire  [OperandW-1:0]  b_den_i,
  // output channel
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [DataW-1:0]     res_num_o,
  output logic [DataW-1:0]     res_den_o,
  output logic                 zero_divisor_o
);

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_MUL       = 9'b000000010,
    ST_GCD_START = 9'b000000100,
    ST_GCD_WAIT  = 9'b000001000,
    ST_QN_START  = 9'b000010000,
    ST_QN_WAIT   = 9'b000100000,
    ST_QD_START  = 9'b001000000,
    ST_QD_WAIT   = 9'b010000000,
    ST_OUT       = 9'b100000000
  } state_e;

  state_e           state_q, state_d;
  logic [1:0]       mstep_q, mstep_d;
  rar_op_e          op_q, op_d;
  logic [DataW-1:0] an_q, ad_q, bn_q, bd_q;
  logic [DataW-1:0] an_d, ad_d, bn_d, bd_d;
  logic [DataW-1:0] rn_q, rn_d;
  logic [DataW-1:0] rd_q, rd_d;
  logic [DataW-1:0] x_q, x_d;
  logic [DataW-1:0] y_q, y_d;
  logic [DataW-1:0] res_num_q, res_num_d;
  logic [DataW-1:0] res_den_q, res_den_d;
  logic             zdiv_q, zdiv_d;

  logic             in_fire;
  logic [DataW-1:0] mul_a, mul_b, prod;
  rar_div_req_t     div_req;
  rar_div_rsp_t     div_rsp;

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = (state_q == ST_OUT);
  assign in_fire        = in_valid_i && !in_stall_o;
  assign res_num_o      = res_num_q;
  assign res_den_o      = res_den_q;
  assign zero_divisor_o = zdiv_q;

  // shared multiplier, operands picked by step; low word is the wrapped product
  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    case (mstep_q)
      2'd0: begin
        mul_a = an_q;
        mul_b = (op_q == OP_MUL) ? bn_q : bd_q;
      end
      2'd1: begin
        mul_a = ad_q;
        mul_b = (op_q == OP_DIV) ? bn_q : bd_q;
      end
      default: begin
        mul_a = ad_q;
        mul_b = bn_q;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  rar_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    mstep_d   = mstep_q;
    op_d      = op_q;
    an_d      = an_q;
    ad_d      = ad_q;
    bn_d      = bn_q;
    bd_d      = bd_q;
    rn_d      = rn_q;
    rd_d      = rd_q;
    x_d       = x_q;
    y_d       = y_q;
    res_num_d = res_num_q;
    res_den_d = res_den_q;
    zdiv_d    = zdiv_q;
    div_req.start    = 1'b0;
    div_req.dividend = y_q;
    div_req.divisor  = x_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d    = rar_op_e'(req_type_i);
          an_d    = sext_operand(a_num_i, OPERAND_BITS);
          ad_d    = sext_operand(a_den_i, OPERAND_BITS);
          bn_d    = sext_operand(b_num_i, OPERAND_BITS);
          bd_d    = sext_operand(b_den_i, OPERAND_BITS);
          mstep_d = 2'd0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        mstep_d = mstep_q + 2'd1;
        case (mstep_q)
          2'd0: rn_d = prod;
          2'd1: begin
            rd_d = prod;
            if (op_q == OP_MUL || op_q == OP_DIV) begin
              x_d     = rn_q;
              y_d     = prod;
              state_d = ST_GCD_START;
            end
          end
          default: begin
            rn_d    = (op_q == OP_SUB) ? (rn_q - prod) : (rn_q + prod);
            x_d     = (op_q == OP_SUB) ? (rn_q - prod) : (rn_q + prod);
            y_d     = rd_q;
            state_d = ST_GCD_START;
          end
        endcase
      end
      // euclid: while x is nonzero, (x, y) becomes (y rem x, x)
      ST_GCD_START: begin
        if (x_q != '0) begin
          div_req.start = 1'b1;
          state_d       = ST_GCD_WAIT;
        end else if (y_q == '0) begin
          res_num_d = '0;
          res_den_d = '0;
          zdiv_d    = 1'b1;
          state_d   = ST_OUT;
        end else begin
          state_d = ST_QN_START;
        end
      end
      ST_GCD_WAIT: begin
        if (div_rsp.done) begin
          y_d     = x_q;
          x_d     = div_rsp.rem;
          state_d = ST_GCD_START;
        end
      end
      // reduce numerator by the divisor
      ST_QN_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = rn_q;
        div_req.divisor  = y_q;
        state_d          = ST_QN_WAIT;
      end
      ST_QN_WAIT: begin
        if (div_rsp.done) begin
          res_num_d = div_rsp.quot;
          state_d   = ST_QD_START;
        end
      end
      // reduce denominator by the divisor
      ST_QD_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = rd_q;
        div_req.divisor  = y_q;
        state_d          = ST_QD_WAIT;
      end
      ST_QD_WAIT: begin
        if (div_rsp.done) begin
          res_den_d = div_rsp.quot;
          zdiv_d    = 1'b0;
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mstep_q <= 2'd0;
    end else begin
      state_q <= state_d;
      mstep_q <= mstep_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    an_q      <= an_d;
    ad_q      <= ad_d;
    bn_q      <= bn_d;
    bd_q      <= bd_d;
    rn_q      <= rn_d;
    rd_q      <= rd_d;
    x_q       <= x_d;
    y_q       <= y_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    zdiv_q    <= zdiv_d;
  end

  // a transaction is never taken while a result is on offer
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input ready while result pending");

  // an accepted transaction blocks the input on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a zero divisor result always reads as 0/0
  a_zero_divisor_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_divisor_o |-> (res_num_o == '0) && (res_den_o == '0))
    else $error("zero divisor result not 0/0");

endmodule

`default_nettype wire

[rtl/core/rar_divider.sv]
// iterative signed divider, truncated quotient and remainder, one bit per cycle
`default_nettype none

module rar_divider
  import rar_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire rar_div_req_t req_i,
  output rar_div_rsp_t      rsp_o
);

  localparam int CntW = $clog2(DataW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] dmag_q, dmag_d;
  logic             qneg_q, qneg_d;
  logic             rneg_q, rneg_d;

  logic [DataW:0]   shifted;
  logic [DataW:0]   diff;
  logic             fits;
  logic [DataW-1:0] dvd_mag;
  logic [DataW-1:0] dvs_mag;

  // magnitudes of the operands
  assign dvd_mag = req_i.dividend[DataW-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;
  assign dvs_mag = req_i.divisor[DataW-1]  ? (~req_i.divisor + 1'b1)  : req_i.divisor;

  // restoring step: shift in next dividend bit, subtract if it fits
  assign shifted = {rem_q, quo_q[DataW-1]};
  assign diff    = shifted - {1'b0, dmag_q};
  assign fits    = (shifted >= {1'b0, dmag_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dmag_d = dmag_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dvd_mag;
      dmag_d = dvs_mag;
      qneg_d = req_i.dividend[DataW-1] ^ req_i.divisor[DataW-1];
      rneg_d = req_i.dividend[DataW-1];
    end else if (busy_q) begin
      rem_d = fits ? diff[DataW-1:0] : shifted[DataW-1:0];
      quo_d = {quo_q[DataW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DataW-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dmag_q <= dmag_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  // signed results: quotient sign from both operands, remainder follows the dividend
  assign rsp_o.done = done_q;
  assign rsp_o.quot = qneg_q ? (~quo_q + 1'b1) : quo_q;
  assign rsp_o.rem  = rneg_q ? (~rem_q + 1'b1) : rem_q;

endmodule

`default_nettype wire

[dv/rational_arith_reduce_core_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the rational arithmetic reduction core

module rational_arith_reduce_core_tb
  import rar_pkg::*;
();

  localparam int NumRandom  = 350;
  localparam int HoldCycles = 4000;
  localparam int DrainCycles = 2000;
  localparam int MaxCycles  = 3_000_000;

  // one reduced fraction as the core should return it, tagged with its transaction
  typedef struct packed {
    logic [31:0]      idx;
    logic [DataW-1:0] num;
    logic [DataW-1:0] den;
    logic             zdiv;
  } fraction_t;

  // one directed row; the result is typed in only where it is obvious
  typedef struct packed {
    rar_op_e             op;
    logic [OperandW-1:0] an;
    logic [OperandW-1:0] ad;
    logic [OperandW-1:0] bn;
    logic [OperandW-1:0] bd;
    logic                typed;
    logic [DataW-1:0]    num;
    logic [DataW-1:0]    den;
    logic                zdiv;
  } fraction_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OpW-1:0]      req_type_i;
  logic [OperandW-1:0] a_num_i;
  logic [OperandW-1:0] a_den_i;
  logic [OperandW-1:0] b_num_i;
  logic [OperandW-1:0] b_den_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [DataW-1:0]    res_num_o;
  logic [DataW-1:0]    res_den_o;
  logic                zero_divisor_o;

  fraction_t pending_results[$];
  int        mismatch_count = 0;
  int        accepted_count = 0;
  int        cycle_count    = 0;
  int        send_idle_pct  = 27;
  int        recv_idle_pct  = 81;
  bit        hold_req       = 1'b0;

  // directed rows: reduction basics, zero denominators, both-parts-zero error,
  // negative divisor from truncated remainder, operand extremes, 32-bit wrap
  fraction_row_t dir_rows [22] = '{
    '{OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b1, 32'sd5, 32'sd6, 1'b0},
    '{OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 1'b1, 32'sd0, 32'sd1, 1'b0},
    '{OP_MUL, 16'sd0, 16'sd0, 16'sd5, 16'sd7, 1'b1, 32'sd0, 32'sd0, 1'b1},
    '{OP_DIV, 16'sd3, 16'sd0, 16'sd0, 16'sd4, 1'b1, 32'sd1, 32'sd0, 1'b0},
    '{OP_DIV, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 1'b1, 32'sd0, 32'sd0, 1'b1},
    '{OP_MUL, -16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b1, 32'sd1, -32'sd6, 1'b0},
    '{OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, -32'sd2, 32'sd1, 1'b0},
    '{OP_MUL, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 32'sd1, 32'sd1, 1'b0},
    '{OP_MUL, -16'sd32767, 16'sd1, 16'sd32767, 16'sd1, 1'b1,
      -32'sd1073676289, 32'sd1, 1'b0},
    '{OP_SUB, 16'sd0, -16'sd1, 16'sd1, 16'sd0, 1'b1, 32'sd1, 32'sd0, 1'b0},
    '{OP_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd0, 1'b1, 32'sd0, 32'sd0, 1'b1},
    '{OP_SUB, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1, 32'sd0, 32'sd1, 1'b0},
    '{OP_ADD, 16'sd32767, 16'h8000, 16'h8000, 16'sd32767, 1'b0, '0, '0, 1'b0},
    '{OP_SUB, 16'h8000, 16'sd32767, 16'sd32767, 16'h8000, 1'b0, '0, '0, 1'b0},
    '{OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0, '0, 1'b0},
    '{OP_DIV, 16'sd12, -16'sd18, 16'sd4, 16'sd6, 1'b0, '0, '0, 1'b0},
    '{OP_ADD, -16'sd6, 16'sd4, 16'sd3, -16'sd2, 1'b0, '0, '0, 1'b0},
    '{OP_SUB, 16'sd7, -16'sd3, -16'sd5, 16'sd9, 1'b0, '0, '0, 1'b0},
    '{OP_MUL, 16'sd0, -16'sd5, 16'sd9, 16'sd3, 1'b0, '0, '0, 1'b0},
    '{OP_DIV, 16'sd5, 16'sd3, 16'sd0, 16'sd7, 1'b0, '0, '0, 1'b0},
    '{OP_MUL, 16'sd21845, -16'sd21846, -16'sd21846, 16'sd21845, 1'b0, '0, '0, 1'b0},
    '{OP_DIV, 16'sd32767, 16'sd1, 16'h8000, -16'sd1, 1'b0, '0, '0, 1'b0}
  };

  rational_arith_reduce_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .a_num_i        (a_num_i),
    .a_den_i        (a_den_i),
    .b_num_i        (b_num_i),
    .b_den_i        (b_den_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .res_num_o      (res_num_o),
    .res_den_o      (res_den_o),
    .zero_divisor_o (zero_divisor_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // cross-multiply on a 32-bit datapath, then reduce by the euclid divisor,
  // whose sign follows the truncated remainder
  function automatic fraction_t reduce_fraction(rar_op_e op, logic [OperandW-1:0] an,
                                                logic [OperandW-1:0] ad,
                                                logic [OperandW-1:0] bn,
                                                logic [OperandW-1:0] bd);
    longint    n_a, d_a, n_b, d_b;
    longint    raw_num, raw_den, x, y, t;
    fraction_t res;
    n_a = longint'($signed(an));
    d_a = longint'($signed(ad));
    n_b = longint'($signed(bn));
    d_b = longint'($signed(bd));
    case (op)
      OP_ADD: begin
        raw_num = n_a * d_b + d_a * n_b;
        raw_den = d_a * d_b;
      end
      OP_SUB: begin
        raw_num = n_a * d_b - d_a * n_b;
        raw_den = d_a * d_b;
      end
      OP_MUL: begin
        raw_num = n_a * n_b;
        raw_den = d_a * d_b;
      end
      default: begin
        raw_num = n_a * d_b;
        raw_den = d_a * n_b;
      end
    endcase
    // wrap into 32-bit two's complement
    raw_num = longint'(int'(raw_num));
    raw_den = longint'(int'(raw_den));
    x = raw_num;
    y = raw_den;
    while (x != 0) begin
      t = y % x;
      y = x;
      x = t;
    end
    res = '0;
    if (y == 0) begin
      res.zdiv = 1'b1;
    end else begin
      // a quotient of 2^31 wraps to -2^31 here by truncation
      res.num = DataW'(raw_num / y);
      res.den = DataW'(raw_den / y);
    end
    return res;
  endfunction

  // operand mix: small values for real reduction, full range, extremes, zero
  function automatic logic [OperandW-1:0] pick_operand();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return OperandW'(int'($urandom_range(0, 40)) - 20);
    if (sel < 8) return OperandW'($urandom);
    if (sel == 9) return '0;
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h8001;
      2:       return 16'hFFFF;
      3:       return 16'h0001;
      4:       return 16'h7FFF;
      default: return 16'h0000;
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // offer one transaction, with random idle cycles ahead of it
  task automatic send_transaction(rar_op_e op, logic [OperandW-1:0] an,
                                  logic [OperandW-1:0] ad, logic [OperandW-1:0] bn,
                                  logic [OperandW-1:0] bd, logic typed,
                                  fraction_t typed_val);
    fraction_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = op;
    a_num_i    = an;
    a_den_i    = ad;
    b_num_i    = bn;
    b_den_i    = bd;
    want       = typed ? typed_val : reduce_fraction(op, an, ad, bn, bd);
    want.idx   = accepted_count;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(want);
    accepted_count++;
    @(negedge clk_i);
  endtask

  // result side stall, with one long hold-off on request
  initial begin
    int hold_cnt;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        for (hold_cnt = 0; hold_cnt < HoldCycles; hold_cnt++) begin
          out_stall_i = 1'b1;
          @(negedge clk_i);
        end
        hold_req = 1'b0;
      end
      out_stall_i = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // compare each accepted result with the oldest pending one
  always @(posedge clk_i) begin
    fraction_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result %0d/%0d with no pending transaction",
                                $signed(res_num_o), $signed(res_den_o)));
      end else begin
        want = pending_results.pop_front();
        if (res_num_o !== want.num)
          flag_mismatch($sformatf("transaction %0d res_num got %0d want %0d", want.idx,
                                  $signed(res_num_o), $signed(want.num)));
        if (res_den_o !== want.den)
          flag_mismatch($sformatf("transaction %0d res_den got %0d want %0d", want.idx,
                                  $signed(res_den_o), $signed(want.den)));
        if (zero_divisor_o !== want.zdiv)
          flag_mismatch($sformatf("transaction %0d zero_divisor got %b want %b",
                                  want.idx, zero_divisor_o, want.zdiv));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MaxCycles) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // reset, directed rows, then three random phases
  initial begin
    fraction_t typed_val;
    int        k;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = OP_ADD;
    a_num_i    = '0;
    a_den_i    = '0;
    b_num_i    = '0;
    b_den_i    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      typed_val      = '0;
      typed_val.num  = dir_rows[i].num;
      typed_val.den  = dir_rows[i].den;
      typed_val.zdiv = dir_rows[i].zdiv;
      send_transaction(dir_rows[i].op, dir_rows[i].an, dir_rows[i].ad, dir_rows[i].bn,
                       dir_rows[i].bd, dir_rows[i].typed, typed_val);
    end

    for (k = 0; k < NumRandom; k++) begin
      // swap idle rates, then no idling with one long result hold-off
      if (k == NumRandom / 3) begin
        send_idle_pct = 81;
        recv_idle_pct = 27;
      end
      if (k == 2 * NumRandom / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
      end
      send_transaction(rar_op_e'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                       pick_operand(), pick_operand(), 1'b0, '0);
    end
    in_valid_i = 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rar_pkg.sv
rtl/core/rar_divider.sv
rtl/core/rational_arith_reduce_core.sv
dv/rational_arith_reduce_core_tb.sv
